// ----- hdl/lpd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpd_pkg: shared types and constants of the Lp distance accumulator
// Field widths, norm mode codes, register map and the words passed between
// the front end, the term queue and the back end.
// ----------------------------------------------------------------------------
package lpd_pkg;

  localparam int unsigned COORD_W     = 16;
  localparam int unsigned MAG_W       = 16;
  localparam int unsigned TERM_W      = 32;
  localparam int unsigned SUM_W       = 42;
  localparam int unsigned DIST_W      = 52;
  localparam int unsigned MODE_W      = 2;
  // A sum wider than this many bits squares to more than DIST_W bits.
  localparam int unsigned HALF_W      = 26;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam int unsigned CFG_ADDR_W  = 3;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned REG_IDX_W   = CFG_ADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_NORM_MODE = 1'b0;

  localparam logic [MODE_W-1:0] MODE_HALF  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_L1    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_L2    = 2'd2;
  localparam logic [MODE_W-1:0] MODE_RESET = MODE_L1;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  typedef struct packed {
    logic signed [COORD_W-1:0] coord_first;
    logic signed [COORD_W-1:0] coord_second;
    logic                      last_element;
  } in_word_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              saturated;
  } out_word_t;

  typedef struct packed {
    logic [TERM_W-1:0] term;
    logic [MODE_W-1:0] mode;
    logic              last;
  } term_word_t;

endpackage

// ----- hdl/lp_distance_accumulator.sv -----
`timescale 1ns / 1ps
// The front end holds off a new input word until the current term is pushed into
// the queue, and in L1/2 mode also while the 16-step bit-serial square root runs.
// The final L2 square root is a 21-step unit in the back end; the queue keeps
// accepting words, until it is full, while it runs or while a result waits.
// Reset clears the running sum, the flags and the queue; norm_mode returns to L1.
// ----------------------------------------------------------------------------
// lp_distance_accumulator: streaming Minkowski Lp distance
// Accumulates per-element L1, L2 or L1/2 terms of coordinate pairs and emits
// the distance of a vector on its last pair. Norm selected by an APB register.
// ----------------------------------------------------------------------------
module lp_distance_accumulator #(
  parameter int unsigned QUEUE_DEPTH = lpd_pkg::QUEUE_DEPTH
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  lpd_pkg::in_word_t               in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output lpd_pkg::out_word_t              out_data_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lpd_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [lpd_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [lpd_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import lpd_pkg::*;

  logic [MODE_W-1:0] norm_mode_q;
  logic              cfg_hit;

  logic              push;
  term_word_t        push_data;
  logic              full;
  logic              pop;
  term_word_t        pop_data;
  logic              empty;

  assign cfg_hit = (paddr[CFG_ADDR_W-1:2] == REG_NORM_MODE);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      norm_mode_q <= MODE_RESET;
    end else if (psel && penable && pwrite && cfg_hit) begin
      norm_mode_q <= pwdata[MODE_W-1:0];
    end
  end

  assign prdata = cfg_hit ? CFG_DATA_W'(norm_mode_q) : '0;

  lpd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .norm_mode_i (norm_mode_q),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  lpd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .empty_o     (empty)
  );

  lpd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .pop_o       (pop),
    .pop_data_i  (pop_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- hdl/lpd_isqrt.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpd_isqrt: iterative integer floor square root
// Restoring digit recurrence, one root bit per cycle. The root is valid from
// the cycle done_o pulses until the next start.
// ----------------------------------------------------------------------------
module lpd_isqrt #(
  parameter int unsigned W = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [W-1:0]     value_i,
  output logic             done_o,
  output logic [W/2-1:0]   root_o
);
  localparam int unsigned R     = W / 2;
  localparam int unsigned CNT_W = $clog2(R + 1);

  logic [CNT_W-1:0] cnt_q;
  logic             done_q;
  logic [W-1:0]     val_q;
  logic [R+1:0]     rem_q;
  logic [R-1:0]     root_q;

  logic [R+1:0]     rem_shift;
  logic [R+1:0]     trial;
  logic             fits;

  always_comb begin
    rem_shift = {rem_q[R-1:0], val_q[W-1 -: 2]};
    trial     = {root_q, 2'b01};
    fits      = rem_shift >= trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= CNT_W'(R);
      end else if (cnt_q != '0) begin
        cnt_q  <= cnt_q - 1'b1;
        done_q <= (cnt_q == CNT_W'(1));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      val_q  <= value_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (cnt_q != '0) begin
      val_q  <= {val_q[W-3:0], 2'b00};
      rem_q  <= fits ? rem_shift - trial : rem_shift;
      root_q <= {root_q[R-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

// ----- hdl/lpd_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpd_front: coordinate intake and per-element term
// Takes one coordinate pair, forms |first - second| and turns it into the
// term of the selected norm, then pushes the term into the queue.
// ----------------------------------------------------------------------------
module lpd_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  lpd_pkg::in_word_t           in_data_i,
  input  logic [lpd_pkg::MODE_W-1:0]  norm_mode_i,
  output logic                        push_o,
  output lpd_pkg::term_word_t         push_data_o,
  input  logic                        full_i
);
  import lpd_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_ROOT = 2'd1;
  localparam logic [1:0] ST_PUSH = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [MAG_W-1:0]  mag_q;
  logic [MODE_W-1:0] mode_q;
  logic              last_q;

  logic [COORD_W:0]  diff;
  logic [COORD_W:0]  diff_neg;
  logic [MAG_W-1:0]  mag;
  logic              accept;
  logic              root_start;
  logic              root_done;
  logic [MAG_W-1:0]  root;
  logic [TERM_W-1:0] square;
  logic [TERM_W-1:0] term;

  // The difference needs one bit more than a coordinate; its magnitude fits in 16.
  always_comb begin
    diff     = {in_data_i.coord_first[COORD_W-1], in_data_i.coord_first}
             - {in_data_i.coord_second[COORD_W-1], in_data_i.coord_second};
    diff_neg = '0 - diff;
    mag      = diff[COORD_W] ? diff_neg[MAG_W-1:0] : diff[MAG_W-1:0];
  end

  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o = (state_q != ST_IDLE);
  assign root_start = accept && (norm_mode_i == MODE_HALF);

  lpd_isqrt #(
    .W (2 * MAG_W)
  ) u_root (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (root_start),
    .value_i ({mag, {MAG_W{1'b0}}}),
    .done_o  (root_done),
    .root_o  (root)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = (norm_mode_i == MODE_HALF) ? ST_ROOT : ST_PUSH;
        end
      end
      ST_ROOT: begin
        if (root_done) begin
          state_d = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (!full_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mag_q  <= mag;
      mode_q <= norm_mode_i;
      last_q <= in_data_i.last_element;
    end
  end

  assign square = TERM_W'(mag_q) * TERM_W'(mag_q);

  always_comb begin
    case (mode_q)
      MODE_HALF: term = TERM_W'(root);
      MODE_L2:   term = square;
      default:   term = TERM_W'(mag_q);
    endcase
  end

  assign push_o           = (state_q == ST_PUSH) && !full_i;
  assign push_data_o.term = term;
  assign push_data_o.mode = mode_q;
  assign push_data_o.last = last_q;

endmodule

// ----- hdl/lpd_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpd_queue: term queue between front end and back end
// Small first-in first-out buffer of term words.
// ----------------------------------------------------------------------------
module lpd_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  lpd_pkg::term_word_t push_data_i,
  output logic                full_o,
  input  logic                pop_i,
  output lpd_pkg::term_word_t pop_data_o,
  output logic                empty_o
);
  import lpd_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  term_word_t       mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q;
  logic [PTR_W-1:0] rd_ptr_q;
  logic [CNT_W-1:0] count_q;

  assign full_o     = (count_q == CNT_W'(DEPTH));
  assign empty_o    = (count_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ----- hdl/lpd_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpd_back: saturating accumulation and final distance
// Adds each term into the running sum and, on the last term of a vector,
// forms the distance of the selected norm in the output register.
// ----------------------------------------------------------------------------
module lpd_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                empty_i,
  output logic                pop_o,
  input  lpd_pkg::term_word_t pop_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output lpd_pkg::out_word_t  out_data_o
);
  import lpd_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SQUARE = 2'd1;
  localparam logic [1:0] ST_ROOT   = 2'd2;

  logic [1:0]        state_q;
  logic [SUM_W-1:0]  sum_q;
  logic              ovf_q;
  logic              out_valid_q;
  out_word_t         out_q;
  logic [SUM_W-1:0]  fin_sum_q;
  logic              fin_sat_q;

  logic [SUM_W:0]    total;
  logic              clip;
  logic [SUM_W-1:0]  sum_add;
  logic              ovf_add;
  logic              pop;
  logic              finish;
  logic              root_start;
  logic              root_done;
  logic [SUM_W/2-1:0] root;
  logic              too_wide;
  logic [DIST_W-1:0] product;

  always_comb begin
    total   = {1'b0, sum_q} + (SUM_W + 1)'(pop_data_i.term);
    clip    = total >= {1'b0, SUM_MAX};
    sum_add = clip ? SUM_MAX : total[SUM_W-1:0];
    ovf_add = ovf_q | clip;
  end

  // A last word waits until the output register is free.
  assign pop        = (state_q == ST_IDLE) && !empty_i && (!pop_data_i.last || !out_valid_q);
  assign finish     = pop && pop_data_i.last;
  assign root_start = finish && (pop_data_i.mode == MODE_L2);
  assign pop_o      = pop;

  lpd_isqrt #(
    .W (SUM_W)
  ) u_root (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (root_start),
    .value_i (sum_add),
    .done_o  (root_done),
    .root_o  (root)
  );

  assign too_wide = (fin_sum_q[SUM_W-1:HALF_W] != '0);
  assign product  = DIST_W'(fin_sum_q[HALF_W-1:0]) * DIST_W'(fin_sum_q[HALF_W-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sum_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (finish) begin
            sum_q <= '0;
            ovf_q <= 1'b0;
            case (pop_data_i.mode)
              MODE_HALF: state_q <= ST_SQUARE;
              MODE_L2:   state_q <= ST_ROOT;
              default:   out_valid_q <= 1'b1;
            endcase
          end else if (pop) begin
            sum_q <= sum_add;
            ovf_q <= ovf_add;
          end
        end
        ST_SQUARE: begin
          out_valid_q <= 1'b1;
          state_q     <= ST_IDLE;
        end
        ST_ROOT: begin
          if (root_done) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      fin_sum_q <= sum_add;
      fin_sat_q <= ovf_add;
      out_q.distance  <= DIST_W'(sum_add);
      out_q.saturated <= ovf_add;
    end else if (state_q == ST_SQUARE) begin
      out_q.distance  <= too_wide ? {DIST_W{1'b1}} : product;
      out_q.saturated <= fin_sat_q | too_wide;
    end else if (state_q == ST_ROOT && root_done) begin
      out_q.distance  <= DIST_W'(root);
      out_q.saturated <= fin_sat_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef ASSERT_OFF
  a_sat_holds_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> (sum_q == SUM_MAX))
    else $error("saturation flag set with running sum below maximum");

  a_final_needs_free_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !out_valid_q)
    else $error("final step running while output register is occupied");

  a_sum_clears_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish |=> (sum_q == '0 && !ovf_q))
    else $error("running sum not cleared after last word of a vector");
`endif

endmodule
